>>> rtl/mbrp_pkg.sv
// Modbus RTU request parser: shared constants, codes and helper functions.
// Used by the channel interfaces and the top level; no dependencies.
package mbrp_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int EN_W   = 12;
    localparam int EXC_W  = 2;

    localparam int MAX_FRAME_BYTES_DEF = 256;
    localparam int MAX_READ_REGISTERS  = 125;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Function codes, as held in the 16-bit code register
    localparam logic [15:0] FC_READ_COILS     = 16'h0001;
    localparam logic [15:0] FC_READ_DISCRETE  = 16'h0002;
    localparam logic [15:0] FC_READ_HOLDING   = 16'h0003;
    localparam logic [15:0] FC_READ_INPUT     = 16'h0004;
    localparam logic [15:0] FC_WRITE_COIL     = 16'h0005;
    localparam logic [15:0] FC_WRITE_REG      = 16'h0006;
    localparam logic [15:0] FC_READ_EXC_STAT  = 16'h0007;
    localparam logic [15:0] FC_WRITE_COILS    = 16'h000F;
    localparam logic [15:0] FC_WRITE_REGS     = 16'h0010;
    localparam logic [15:0] FC_MASK_WRITE     = 16'h0016;
    localparam logic [15:0] FC_READ_WRITE     = 16'h0017;
    localparam logic [15:0] FC_DEV_ID         = 16'h2B0E;

    // Codes that carry a subfunction byte
    localparam logic [7:0] FC_DIAGNOSTICS = 8'h08;
    localparam logic [7:0] FC_MEI         = 8'h2B;

    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    // Enable register bit positions
    localparam int EN_READ_COILS    = 0;
    localparam int EN_READ_DISCRETE = 1;
    localparam int EN_READ_HOLDING  = 2;
    localparam int EN_READ_INPUT    = 3;
    localparam int EN_WRITE_COIL    = 4;
    localparam int EN_WRITE_REG     = 5;
    localparam int EN_READ_EXC_STAT = 6;
    localparam int EN_WRITE_COILS   = 7;
    localparam int EN_WRITE_REGS    = 8;
    localparam int EN_MASK_WRITE    = 9;
    localparam int EN_READ_WRITE    = 10;

    // Exception codes
    localparam logic [EXC_W-1:0] EXC_NONE             = 2'd0;
    localparam logic [EXC_W-1:0] EXC_ILLEGAL_FUNCTION = 2'd1;
    localparam logic [EXC_W-1:0] EXC_ILLEGAL_ADDRESS  = 2'd2;
    localparam logic [EXC_W-1:0] EXC_ILLEGAL_VALUE    = 2'd3;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One byte of the reflected CRC-16, bit at a time
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Data bytes in each function's fixed header
    function automatic logic [3:0] fixed_len(input logic [15:0] code);
        logic [3:0] n;
        unique case (code) inside
            FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
            FC_WRITE_COIL, FC_WRITE_REG:   n = 4'd4;
            FC_WRITE_COILS, FC_WRITE_REGS: n = 4'd5;
            FC_MASK_WRITE:                 n = 4'd6;
            FC_READ_WRITE:                 n = 4'd9;
            FC_DEV_ID:                     n = 4'd2;
            default:                       n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/mbrp_if.sv
// Valid/ready channel interfaces: received bytes in, parser results out.
// Depends on mbrp_pkg for field widths.
interface mbrp_in_if import mbrp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mbrp_res_if import mbrp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_ok;
    logic [EXC_W-1:0]  exception_code;
    logic [BYTE_W-1:0] slave_id;
    logic [WORD_W-1:0] function_code;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [WORD_W-1:0] word_c;
    logic [WORD_W-1:0] word_d;
    logic [BYTE_W-1:0] byte_count;
    logic              last_of_run;

    modport source (
        output valid, output kind, output payload_byte, output frame_ok,
        output exception_code, output slave_id, output function_code,
        output word_a, output word_b, output word_c, output word_d,
        output byte_count, output last_of_run, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input frame_ok,
        input exception_code, input slave_id, input function_code,
        input word_a, input word_b, input word_c, input word_d,
        input byte_count, input last_of_run, output ready
    );
endinterface

>>> rtl/modbus_rtu_request_parser.sv
// Modbus RTU request parser top level: CRC check, header decode, payload pass-on.
// Depends on mbrp_pkg and the channel interfaces in mbrp_if.sv.
//
// Usage
//   i_rx  : one received byte per item, frame_end set on the frame's last byte.
//   o_res : payload items (kind 0) for data bytes past the fixed header, and
//           one summary item (kind 1) per frame with the decoded header words
//           and the exception code. last_of_run marks the final item that an
//           input byte causes.
//   i_cfg_we / i_cfg_data : writes the function enable mask; write only while idle.
// Timing
//   An item is held in the input register, then its results go into a two-entry
//   result queue once they fit; o_res shows the head of the queue.
//   One byte per cycle is sustained while o_res.ready is high; the two results
//   of a frame's last byte fill the queue, which drains on the next frame's
//   opening bytes (they give none), so the input never waits.
//   The two most recent bytes are held back, so the CRC is never passed on.
// Reset
//   Synchronous, active low. Clears the queue, the frame state and the enable
//   mask (all functions disabled except device identification).
// Stall
//   With o_res.ready low the queue fills and i_rx.ready drops; nothing is lost.
module modbus_rtu_request_parser
    import mbrp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [EN_W-1:0] i_cfg_data,
    mbrp_in_if.sink         i_rx,
    mbrp_res_if.source      o_res
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_ok;
        logic [EXC_W-1:0]  exception_code;
        logic [BYTE_W-1:0] slave_id;
        logic [WORD_W-1:0] function_code;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
        logic [WORD_W-1:0] word_d;
        logic [BYTE_W-1:0] byte_count;
        logic              last_of_run;
    } t_result;

    // ---- configuration ----
    logic [EN_W-1:0] r_en;

    // ---- input register ----
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;

    // ---- frame state ----
    logic [15:0]             r_crc,   n_crc;
    logic [POS_W-1:0]        r_pos,   n_pos;
    logic [BYTE_W-1:0]       r_dly0,  r_dly1;
    logic [3:0][WORD_W-1:0]  r_hdr,   n_hdr;
    logic [BYTE_W-1:0]       r_id,    n_id;
    logic [WORD_W-1:0]       r_code,  n_code;
    logic [BYTE_W-1:0]       r_count, n_count;
    logic                    r_ovf,   n_ovf;

    // ---- result queue ----
    t_result    r_q [2];
    t_result    n_q0, n_q1;
    logic [1:0] r_cnt, n_cnt;

    // ---- decode ----
    logic [POS_W-1:0] w_q, w_k;
    logic             w_hl3, w_pay;
    t_result          w_pres, w_sres, w_first;

    // ---- summary ----
    logic             w_ok, w_fn_en, w_short;
    logic [3:0]       w_fl, w_lim;
    logic [EXC_W-1:0] w_exc;
    logic [WORD_W-1:0] w_wa, w_wb, w_wc, w_wd;
    logic [BYTE_W-1:0] w_bc;

    // ---- flow ----
    logic       w_pop, w_fit, w_adv;
    logic [1:0] w_new, w_rem;

    // Byte handling: CRC, position, and the byte confirmed two places back
    always_comb begin
        n_crc   = crc16_update(r_crc, r_in_byte);
        n_ovf   = r_ovf | (r_pos >= POS_W'(MAX_FRAME_BYTES));
        n_pos   = (r_pos < POS_W'(MAX_FRAME_BYTES)) ? r_pos + POS_W'(1) : r_pos;
        n_hdr   = r_hdr;
        n_id    = r_id;
        n_code  = r_code;
        n_count = r_count;
        w_pay   = 1'b0;
        w_q     = r_pos - POS_W'(2);
        // header is three bytes long once a subfunction follows the code
        w_hl3   = (r_code[15:8] != '0) || (r_code == {8'h00, FC_DIAGNOSTICS})
                  || (r_code == {8'h00, FC_MEI});
        w_k     = w_q - (w_hl3 ? POS_W'(3) : POS_W'(2));
        if (r_pos >= POS_W'(2)) begin
            if (w_q == '0) begin
                n_id   = r_dly1;
                n_code = '0;
            end else if (w_q == POS_W'(1)) begin
                n_code = {8'h00, r_dly1};
            end else if (w_q == POS_W'(2) && w_hl3) begin
                n_code = {r_code[7:0], r_dly1};
            end else begin
                // big-endian pairs into the header words, ninth byte is the count
                if (w_k < POS_W'(8)) begin
                    if (w_k[0]) begin
                        n_hdr[w_k[2:1]][7:0] = r_dly1;
                    end else begin
                        n_hdr[w_k[2:1]][15:8] = r_dly1;
                    end
                end else if (w_k == POS_W'(8)) begin
                    n_count = r_dly1;
                end
                w_pay = (w_k >= POS_W'(fixed_len(r_code)));
            end
        end
    end

    // Frame summary, from the state as it stands after this byte
    always_comb begin
        w_ok  = (n_crc == '0) && (n_pos >= POS_W'(4)) && !n_ovf;
        w_fl  = fixed_len(n_code);
        w_lim = ((n_code[15:8] != '0) ? 4'd3 : 4'd2) + 4'd2 + w_fl;
        w_short = (w_fl != '0) && (n_pos < POS_W'(w_lim));

        unique case (n_code) inside
            FC_READ_COILS:    w_fn_en = r_en[EN_READ_COILS];
            FC_READ_DISCRETE: w_fn_en = r_en[EN_READ_DISCRETE];
            FC_READ_HOLDING:  w_fn_en = r_en[EN_READ_HOLDING];
            FC_READ_INPUT:    w_fn_en = r_en[EN_READ_INPUT];
            FC_WRITE_COIL:    w_fn_en = r_en[EN_WRITE_COIL];
            FC_WRITE_REG:     w_fn_en = r_en[EN_WRITE_REG];
            FC_READ_EXC_STAT: w_fn_en = r_en[EN_READ_EXC_STAT];
            FC_WRITE_COILS:   w_fn_en = r_en[EN_WRITE_COILS];
            FC_WRITE_REGS:    w_fn_en = r_en[EN_WRITE_REGS];
            FC_MASK_WRITE:    w_fn_en = r_en[EN_MASK_WRITE];
            FC_READ_WRITE:    w_fn_en = r_en[EN_READ_WRITE];
            default:          w_fn_en = 1'b0;
        endcase

        w_exc = EXC_NONE;
        w_wa  = '0;
        w_wb  = '0;
        w_wc  = '0;
        w_wd  = '0;
        w_bc  = '0;
        if (n_code == FC_DEV_ID) begin
            // device identification is always served
            w_wa = {8'h00, n_hdr[0][15:8]};
            w_wb = {8'h00, n_hdr[0][7:0]};
        end else if (!w_fn_en) begin
            w_exc = EXC_ILLEGAL_FUNCTION;
        end else begin
            unique case (n_code) inside
                FC_READ_COILS, FC_READ_DISCRETE: begin
                    w_wa = n_hdr[0];
                    w_wb = n_hdr[1];
                    if (n_hdr[1] == '0) w_exc = EXC_ILLEGAL_ADDRESS;
                end
                FC_READ_HOLDING, FC_READ_INPUT: begin
                    w_wa = n_hdr[0];
                    w_wb = n_hdr[1];
                    if (n_hdr[1] == '0 || n_hdr[1] > WORD_W'(MAX_READ_REGISTERS))
                        w_exc = EXC_ILLEGAL_ADDRESS;
                end
                FC_WRITE_COIL: begin
                    w_wa = n_hdr[0];
                    w_wb = {15'd0, n_hdr[1][15:8] != '0};
                    if (n_hdr[1] != COIL_ON && n_hdr[1] != COIL_OFF)
                        w_exc = EXC_ILLEGAL_VALUE;
                end
                FC_WRITE_REG: begin
                    w_wa = n_hdr[0];
                    w_wb = n_hdr[1];
                end
                FC_WRITE_COILS, FC_WRITE_REGS: begin
                    w_wa = n_hdr[0];
                    w_wb = n_hdr[1];
                    w_bc = n_hdr[2][15:8];
                end
                FC_MASK_WRITE: begin
                    w_wa = n_hdr[0];
                    w_wb = n_hdr[1];
                    w_wc = n_hdr[2] & ~n_hdr[1];
                end
                FC_READ_WRITE: begin
                    w_wa = n_hdr[0];
                    w_wb = n_hdr[1];
                    w_wc = n_hdr[2];
                    w_wd = n_hdr[3];
                    w_bc = n_count;
                end
                default: ;
            endcase
        end
        // header cut short
        if (w_exc == EXC_NONE && w_short) w_exc = EXC_ILLEGAL_VALUE;

        w_sres             = '0;
        w_sres.kind        = KIND_SUMMARY;
        w_sres.last_of_run = 1'b1;
        if (!w_ok) begin
            w_sres.exception_code = EXC_ILLEGAL_VALUE;
        end else begin
            w_sres.frame_ok       = 1'b1;
            w_sres.exception_code = w_exc;
            w_sres.slave_id       = n_id;
            w_sres.function_code  = n_code;
            w_sres.word_a         = w_wa;
            w_sres.word_b         = w_wb;
            w_sres.word_c         = w_wc;
            w_sres.word_d         = w_wd;
            w_sres.byte_count     = w_bc;
        end

        w_pres              = '0;
        w_pres.kind         = KIND_PAYLOAD;
        w_pres.payload_byte = r_dly1;
        w_pres.last_of_run  = !r_in_end;
    end

    // Queue flow: the input register advances only when its results fit
    always_comb begin
        w_pop   = (r_cnt != '0) && o_res.ready;
        w_rem   = r_cnt - {1'b0, w_pop};
        w_new   = {1'b0, w_pay} + {1'b0, r_in_end};
        w_fit   = ({1'b0, w_rem} + {1'b0, w_new}) <= 3'd2;
        w_adv   = r_in_vld && w_fit;
        w_first = w_pay ? w_pres : w_sres;
        n_cnt   = w_rem + (w_adv ? w_new : 2'd0);
        n_q0    = (w_rem == 2'd0) ? w_first : (w_pop ? r_q[1] : r_q[0]);
        unique case (w_rem)
            2'd0:    n_q1 = w_sres;
            2'd1:    n_q1 = w_first;
            default: n_q1 = r_q[1];
        endcase
    end

    assign i_rx.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= '0;
            r_in_vld <= 1'b0;
            r_cnt    <= '0;
            r_crc    <= CRC_INIT;
            r_pos    <= '0;
            r_dly0   <= '0;
            r_dly1   <= '0;
            r_hdr    <= '0;
            r_id     <= '0;
            r_code   <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cfg_we) r_en <= i_cfg_data;
            r_in_vld <= (i_rx.valid && i_rx.ready) || (r_in_vld && !w_adv);
            r_cnt    <= n_cnt;
            if (w_adv) begin
                if (r_in_end) begin
                    // frame done: back to the idle frame state
                    r_crc   <= CRC_INIT;
                    r_pos   <= '0;
                    r_dly0  <= '0;
                    r_dly1  <= '0;
                    r_hdr   <= '0;
                    r_id    <= '0;
                    r_code  <= '0;
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_crc   <= n_crc;
                    r_pos   <= n_pos;
                    r_dly0  <= r_in_byte;
                    r_dly1  <= r_dly0;
                    r_hdr   <= n_hdr;
                    r_id    <= n_id;
                    r_code  <= n_code;
                    r_count <= n_count;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_end  <= i_rx.frame_end;
        end
        r_q[0] <= n_q0;
        r_q[1] <= n_q1;
    end

    assign o_res.valid          = (r_cnt != '0);
    assign o_res.kind           = r_q[0].kind;
    assign o_res.payload_byte   = r_q[0].payload_byte;
    assign o_res.frame_ok       = r_q[0].frame_ok;
    assign o_res.exception_code = r_q[0].exception_code;
    assign o_res.slave_id       = r_q[0].slave_id;
    assign o_res.function_code  = r_q[0].function_code;
    assign o_res.word_a         = r_q[0].word_a;
    assign o_res.word_b         = r_q[0].word_b;
    assign o_res.word_c         = r_q[0].word_c;
    assign o_res.word_d         = r_q[0].word_d;
    assign o_res.byte_count     = r_q[0].byte_count;
    assign o_res.last_of_run    = r_q[0].last_of_run;

    // ---- assertions ----
    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result queue over capacity");

    a_frame_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_end) |=> (r_pos == '0 && r_crc == CRC_INIT && r_code == '0))
        else $error("frame state not cleared after frame end");

    a_bad_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind && !o_res.frame_ok)
        |-> (o_res.exception_code == EXC_ILLEGAL_VALUE && o_res.slave_id == '0))
        else $error("bad frame summary not flagged");

    a_summary_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind) |-> o_res.last_of_run)
        else $error("summary not last of its run");

endmodule

>>> verif/mbrp_tb_pkg.sv
// Checker for the request parser bench: the result item type, the CRC step and a
// class that predicts the parser's results and scores the ones the block gives.
// Depends on mbrp_pkg for widths, function codes, exception codes and enable bits.
`timescale 1ns / 100ps

package mbrp_tb_pkg;
    import mbrp_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_ok;
        logic [EXC_W-1:0]  exception_code;
        logic [BYTE_W-1:0] slave_id;
        logic [WORD_W-1:0] function_code;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
        logic [WORD_W-1:0] word_d;
        logic [BYTE_W-1:0] byte_count;
        logic              last_of_run;
    } parse_result_t;

    // Modbus CRC-16, reflected, one byte
    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    class frame_checker;
        logic [EN_W-1:0]   fn_enable;
        logic [15:0]       crc;
        int unsigned       pos;
        logic [7:0]        held_new;
        logic [7:0]        held_old;
        logic [15:0]       hdr [4];
        logic [7:0]        sid;
        logic [15:0]       fcode;
        logic [7:0]        count_byte;
        bit                overlong;
        parse_result_t     expected_results [$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        function new();
            fn_enable    = '0;
            mismatches   = 0;
            results_seen = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            crc        = 16'hFFFF;
            pos        = 0;
            held_new   = '0;
            held_old   = '0;
            sid        = '0;
            fcode      = '0;
            count_byte = '0;
            overlong   = 0;
            foreach (hdr[i]) hdr[i] = '0;
        endfunction

        function int unsigned header_bytes(logic [15:0] code);
            case (code)
                FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
                FC_WRITE_COIL, FC_WRITE_REG:   return 4;
                FC_WRITE_COILS, FC_WRITE_REGS: return 5;
                FC_MASK_WRITE:                 return 6;
                FC_READ_WRITE:                 return 9;
                FC_DEV_ID:                     return 2;
                default:                       return 0;
            endcase
        endfunction

        function int enable_index(logic [15:0] code);
            case (code)
                FC_READ_COILS:    return EN_READ_COILS;
                FC_READ_DISCRETE: return EN_READ_DISCRETE;
                FC_READ_HOLDING:  return EN_READ_HOLDING;
                FC_READ_INPUT:    return EN_READ_INPUT;
                FC_WRITE_COIL:    return EN_WRITE_COIL;
                FC_WRITE_REG:     return EN_WRITE_REG;
                FC_READ_EXC_STAT: return EN_READ_EXC_STAT;
                FC_WRITE_COILS:   return EN_WRITE_COILS;
                FC_WRITE_REGS:    return EN_WRITE_REGS;
                FC_MASK_WRITE:    return EN_MASK_WRITE;
                FC_READ_WRITE:    return EN_READ_WRITE;
                default:          return -1;
            endcase
        endfunction

        // Byte at frame index q is now past the CRC window; true if it is payload
        function bit confirm(int unsigned q, logic [7:0] b);
            int unsigned hl;
            int unsigned k;
            if (q == 0) begin
                sid   = b;
                fcode = '0;
                return 0;
            end
            if (q == 1) begin
                fcode = {8'h00, b};
                return 0;
            end
            hl = (fcode > 16'h00FF || fcode[7:0] == FC_DIAGNOSTICS || fcode[7:0] == FC_MEI)
                 ? 3 : 2;
            if (q == 2 && hl == 3) begin
                fcode = {fcode[7:0], b};
                return 0;
            end
            k = q - hl;
            if (k < 8) begin
                if (k % 2) hdr[k / 2][7:0] = b;
                else hdr[k / 2][15:8] = b;
            end else if (k == 8) begin
                count_byte = b;
            end
            return k >= header_bytes(fcode);
        endfunction

        function parse_result_t frame_summary();
            parse_result_t r;
            int unsigned   hl;
            int unsigned   ndata;
            int            en_idx;
            r = '0;
            r.kind        = KIND_SUMMARY;
            r.last_of_run = 1'b1;
            if (crc != 16'h0000 || pos < 4 || overlong) begin
                r.exception_code = EXC_ILLEGAL_VALUE;
                return r;
            end
            r.frame_ok      = 1'b1;
            r.slave_id      = sid;
            r.function_code = fcode;
            hl     = (fcode > 16'h00FF) ? 3 : 2;
            ndata  = (pos >= hl + 2) ? pos - hl - 2 : 0;
            en_idx = enable_index(fcode);
            if (fcode == FC_DEV_ID) begin
                r.word_a = {8'h00, hdr[0][15:8]};
                r.word_b = {8'h00, hdr[0][7:0]};
            end else if (en_idx < 0 || !fn_enable[en_idx]) begin
                r.exception_code = EXC_ILLEGAL_FUNCTION;
            end else begin
                case (fcode)
                    FC_READ_COILS, FC_READ_DISCRETE: begin
                        r.word_a = hdr[0];
                        r.word_b = hdr[1];
                        if (hdr[1] == 16'h0000) r.exception_code = EXC_ILLEGAL_ADDRESS;
                    end
                    FC_READ_HOLDING, FC_READ_INPUT: begin
                        r.word_a = hdr[0];
                        r.word_b = hdr[1];
                        if (hdr[1] == 16'h0000 || hdr[1] > MAX_READ_REGISTERS)
                            r.exception_code = EXC_ILLEGAL_ADDRESS;
                    end
                    FC_WRITE_COIL: begin
                        r.word_a = hdr[0];
                        r.word_b = (hdr[1][15:8] != 8'h00) ? 16'd1 : 16'd0;
                        if (hdr[1] != COIL_ON && hdr[1] != COIL_OFF)
                            r.exception_code = EXC_ILLEGAL_VALUE;
                    end
                    FC_WRITE_REG: begin
                        r.word_a = hdr[0];
                        r.word_b = hdr[1];
                    end
                    FC_WRITE_COILS, FC_WRITE_REGS: begin
                        r.word_a     = hdr[0];
                        r.word_b     = hdr[1];
                        r.byte_count = hdr[2][15:8];
                    end
                    FC_MASK_WRITE: begin
                        r.word_a = hdr[0];
                        r.word_b = hdr[1];
                        r.word_c = hdr[2] & ~hdr[1];
                    end
                    FC_READ_WRITE: begin
                        r.word_a     = hdr[0];
                        r.word_b     = hdr[1];
                        r.word_c     = hdr[2];
                        r.word_d     = hdr[3];
                        r.byte_count = count_byte;
                    end
                    default: ;
                endcase
            end
            if (r.exception_code == EXC_NONE && ndata < header_bytes(fcode))
                r.exception_code = EXC_ILLEGAL_VALUE;
            return r;
        endfunction

        // One accepted input item: queue whatever results it causes
        function void take_byte(logic [7:0] b, bit last);
            parse_result_t r;
            if (pos >= MAX_FRAME_BYTES_DEF) overlong = 1;
            crc = crc_next(crc, b);
            if (pos >= 2 && confirm(pos - 2, held_old)) begin
                r = '0;
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = held_old;
                r.last_of_run  = !last;
                expected_results.push_back(r);
            end
            held_old = held_new;
            held_new = b;
            if (pos < MAX_FRAME_BYTES_DEF) pos++;
            if (last) begin
                expected_results.push_back(frame_summary());
                clear_frame();
            end
        endfunction

        task report(string msg);
            $display("[%0t] %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %0h, expected %0h",
                                 results_seen, name, got, want));
        endtask

        task check_result(parse_result_t got);
            parse_result_t want;
            results_seen++;
            if (expected_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind",           16'(got.kind),           16'(want.kind));
            compare_field("payload_byte",   16'(got.payload_byte),   16'(want.payload_byte));
            compare_field("frame_ok",       16'(got.frame_ok),       16'(want.frame_ok));
            compare_field("exception_code", 16'(got.exception_code),
                          16'(want.exception_code));
            compare_field("slave_id",       16'(got.slave_id),       16'(want.slave_id));
            compare_field("function_code",  got.function_code,       want.function_code);
            compare_field("word_a",         got.word_a,              want.word_a);
            compare_field("word_b",         got.word_b,              want.word_b);
            compare_field("word_c",         got.word_c,              want.word_c);
            compare_field("word_d",         got.word_d,              want.word_d);
            compare_field("byte_count",     16'(got.byte_count),     16'(want.byte_count));
            compare_field("last_of_run",    16'(got.last_of_run),    16'(want.last_of_run));
        endtask
    endclass

endpackage

>>> verif/tb_modbus_rtu_request_parser.sv
// Bench for the Modbus RTU request parser: drives framed request bytes with random
// gaps and checks every result item against the frame_checker prediction.
// Depends on mbrp_pkg, the channel interfaces and mbrp_tb_pkg.
`timescale 1ns / 100ps

module tb_modbus_rtu_request_parser;
    import mbrp_pkg::*;
    import mbrp_tb_pkg::*;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no item moving on either side
    localparam int RANDOM_ITEMS = 850;
    localparam int SETTLE       = 8;

    // Everything the generator can pick as a well-formed function
    localparam logic [15:0] SUPPORTED [12] = '{
        FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
        FC_WRITE_COIL, FC_WRITE_REG, FC_READ_EXC_STAT, FC_WRITE_COILS,
        FC_WRITE_REGS, FC_MASK_WRITE, FC_READ_WRITE, FC_DEV_ID
    };

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [EN_W-1:0] i_cfg_data;

    mbrp_in_if  rx_if ();
    mbrp_res_if res_if ();

    frame_checker sb = new();

    logic [7:0] frame_bytes [$];   // frame under construction, CRC included
    bit         hold_request;      // asks the result side for one long hold-off
    bit         res_holding;       // result side is in that hold-off

    modbus_rtu_request_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_if),
        .o_res      (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly back to back, often a short pause, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Bytes and words lean towards the extremes
    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Register quantity around the 1..125 window
    function automatic logic [15:0] pick_quantity();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'(MAX_READ_REGISTERS);
            2:       return 16'(MAX_READ_REGISTERS + 1);
            3:       return 16'd1;
            4:       return 16'($urandom_range(1, MAX_READ_REGISTERS));
            default: return rand_word();
        endcase
    endfunction

    function automatic void push_word(logic [15:0] w);
        frame_bytes.push_back(w[15:8]);
        frame_bytes.push_back(w[7:0]);
    endfunction

    // CRC goes out low byte first, so a clean frame leaves a zero residue
    function automatic void append_crc();
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (frame_bytes[i]) c = crc_next(c, frame_bytes[i]);
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endfunction

    // ------------------------------------------------------------------
    // Frame generation
    // ------------------------------------------------------------------

    // Mostly well-formed requests with random content; a share of runts,
    // truncated headers, odd subfunctions, unknown codes and broken CRCs.
    function automatic void build_random_frame();
        int          pick;
        int          n;
        int          bc_decl;
        logic [15:0] code;
        frame_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            // runt: three bytes carry a good CRC but are still too short
            n = $urandom_range(1, 3);
            if (n == 3) begin
                frame_bytes.push_back(rand_byte());
                append_crc();
            end else begin
                repeat (n) frame_bytes.push_back(rand_byte());
            end
            return;
        end
        frame_bytes.push_back(rand_byte());
        if (pick < 80) code = SUPPORTED[$urandom_range(0, 11)];
        else if (pick < 87) code = {FC_DIAGNOSTICS, rand_byte()};
        else if (pick < 93) code = {FC_MEI, rand_byte()};
        else code = {8'h00, rand_byte()};
        if (code > 16'h00FF) push_word(code);
        else frame_bytes.push_back(code[7:0]);
        case (code)
            FC_READ_COILS, FC_READ_DISCRETE: begin
                push_word(rand_word());
                push_word(($urandom_range(0, 4) == 0) ? 16'h0000 : rand_word());
            end
            FC_READ_HOLDING, FC_READ_INPUT: begin
                push_word(rand_word());
                push_word(pick_quantity());
            end
            FC_WRITE_COIL: begin
                push_word(rand_word());
                case ($urandom_range(0, 2))
                    0:       push_word(COIL_ON);
                    1:       push_word(COIL_OFF);
                    default: push_word(rand_word());
                endcase
            end
            FC_WRITE_REG: begin
                push_word(rand_word());
                push_word(rand_word());
            end
            FC_WRITE_COILS, FC_WRITE_REGS: begin
                push_word(rand_word());
                push_word(rand_word());
                bc_decl = $urandom_range(0, 8);
                frame_bytes.push_back(bc_decl[7:0]);
                repeat (bc_decl) frame_bytes.push_back(rand_byte());
            end
            FC_MASK_WRITE: begin
                repeat (3) push_word(rand_word());
            end
            FC_READ_WRITE: begin
                repeat (4) push_word(rand_word());
                bc_decl = $urandom_range(0, 6);
                frame_bytes.push_back(bc_decl[7:0]);
                repeat (bc_decl) frame_bytes.push_back(rand_byte());
            end
            FC_DEV_ID: begin
                frame_bytes.push_back(rand_byte());
                frame_bytes.push_back(rand_byte());
            end
            default: ;
        endcase
        if ($urandom_range(0, 1) == 1) begin
            n = $urandom_range(1, 6);
            repeat (n) frame_bytes.push_back(rand_byte());
        end
        // short data: chop bytes off the end, which may cut into the header
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 4);
            while (n > 0 && frame_bytes.size() > 1) begin
                void'(frame_bytes.pop_back());
                n--;
            end
        end
        append_crc();
        if ($urandom_range(0, 11) == 0)
            frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] ^=
                8'($urandom_range(1, 255));
    endfunction

    // Multiple-register write padded out to the given total length
    function automatic void build_long_frame(int total);
        frame_bytes.delete();
        frame_bytes.push_back(rand_byte());
        frame_bytes.push_back(FC_WRITE_REGS[7:0]);
        while (frame_bytes.size() < total - 2) frame_bytes.push_back(rand_byte());
        append_crc();
    endfunction

    // ------------------------------------------------------------------
    // Drivers: inputs move on the falling edge
    // ------------------------------------------------------------------

    task automatic idle_in(int cycles);
        @(negedge i_clk);
        rx_if.valid     <= 1'b0;
        rx_if.frame_end <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // valid stays high when items follow back to back
    task automatic send_byte(logic [7:0] b, bit last);
        @(negedge i_clk);
        rx_if.valid     <= 1'b1;
        rx_if.rx_byte   <= b;
        rx_if.frame_end <= last;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
    endtask

    task automatic send_frame(bit calm);
        int gap;
        foreach (frame_bytes[i]) begin
            gap = (calm || res_holding) ? 0 : pick_gap();
            if (gap > 0) idle_in(gap);
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // Stop offering and let every predicted result come out
    task automatic wait_drained();
        idle_in(1);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_enable_mask(logic [EN_W-1:0] mask);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mask;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.fn_enable = mask;
    endtask

    // ------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        parse_result_t got;
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready)
                sb.take_byte(rx_if.rx_byte, rx_if.frame_end);
            if (res_if.valid && res_if.ready) begin
                got.kind           = res_if.kind;
                got.payload_byte   = res_if.payload_byte;
                got.frame_ok       = res_if.frame_ok;
                got.exception_code = res_if.exception_code;
                got.slave_id       = res_if.slave_id;
                got.function_code  = res_if.function_code;
                got.word_a         = res_if.word_a;
                got.word_b         = res_if.word_b;
                got.word_c         = res_if.word_c;
                got.word_d         = res_if.word_d;
                got.byte_count     = res_if.byte_count;
                got.last_of_run    = res_if.last_of_run;
                sb.check_result(got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, one calm stretch, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        stall        = 0;
        res_holding  = 1'b0;
        res_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res_holding  = 1'b1;
                stall        = 120;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
                res_holding  = 1'b0;
                if (sb.results_seen < 300 || sb.results_seen >= 420)
                    stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if nothing moves for too long
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("tb_modbus_rtu_request_parser NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int              frame_no;
        int              items_sent;
        logic [EN_W-1:0] mask;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        rx_if.valid     = 1'b0;
        rx_if.rx_byte   = '0;
        rx_if.frame_end = 1'b0;
        hold_request    = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset mask first. Device identification is always served,
        // a plain read must come back as an illegal function.
        frame_bytes = '{8'h11, FC_MEI, 8'h0E, 8'h01, 8'h00};
        append_crc();
        send_frame(1'b1);
        frame_bytes = '{8'h01, FC_READ_HOLDING[7:0], 8'h00, 8'h10, 8'h00, 8'h02};
        append_crc();
        send_frame(1'b1);

        write_enable_mask({EN_W{1'b1}});
        // single byte flagged as the end of its frame
        frame_bytes = '{8'hFF};
        send_frame(1'b1);
        // good CRC but only three bytes long
        frame_bytes = '{8'h00};
        append_crc();
        send_frame(1'b0);
        // top of the register window, extreme id and address
        frame_bytes = '{8'hFF, FC_READ_HOLDING[7:0], 8'hFF, 8'hFF, 8'h00, 8'h7D};
        append_crc();
        send_frame(1'b0);

        // Random part: new mask every few frames, extremes first
        frame_no   = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (frame_no % 6 == 0) begin
                case (frame_no / 6)
                    0:       mask = '0;
                    1:       mask = {EN_W{1'b1}};
                    default: mask = ($urandom_range(0, 4) == 0) ? {EN_W{1'b1}}
                                                                : EN_W'($urandom_range(0, 4095));
                endcase
                write_enable_mask(mask);
            end
            if (frame_no == 14) begin
                // past the frame limit: the position saturates, frame judged bad
                build_long_frame(MAX_FRAME_BYTES_DEF + 2);
                send_frame(1'b0);
            end else if (frame_no == 27) begin
                // result side holds off while bytes keep coming, so the input stalls
                build_long_frame(48);
                hold_request = 1'b1;
                send_frame(1'b1);
            end else begin
                build_random_frame();
                send_frame($urandom_range(0, 3) == 0);
            end
            items_sent += frame_bytes.size();
            frame_no++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("tb_modbus_rtu_request_parser OK");
        else
            $display("tb_modbus_rtu_request_parser NOT OK");
        $finish;
    end

endmodule

>>> modbus_rtu_request_parser.f
rtl/mbrp_pkg.sv
rtl/mbrp_if.sv
rtl/modbus_rtu_request_parser.sv
verif/mbrp_tb_pkg.sv
verif/tb_modbus_rtu_request_parser.sv
